// ===== rtl/ole_pkg.sv =====
// Shared types, codes and widths of the ordered list engine.
package ole_pkg;

   localparam int DEF_CAPACITY   = 64;
   localparam int DEF_DATA_WIDTH = 32;

   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 7;
   localparam int STATUS_W = 3;
   localparam int LEN_W    = 7;
   localparam int EXT_W    = 64;

   typedef enum logic [KIND_W-1:0] {
      KIND_INS_HEAD  = 3'd0,
      KIND_INS_END   = 3'd1,
      KIND_INS_POS   = 3'd2,
      KIND_DEL_HEAD  = 3'd3,
      KIND_DEL_END   = 3'd4,
      KIND_DEL_VALUE = 3'd5,
      KIND_SEARCH    = 3'd6
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_BADPOS   = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      DP_NOP            = 4'd0,
      DP_LOAD           = 4'd1,
      DP_INIT_UP_HEAD   = 4'd2,
      DP_INIT_UP_END    = 4'd3,
      DP_INIT_UP_POS    = 4'd4,
      DP_INIT_DOWN_HEAD = 4'd5,
      DP_INIT_SEARCH    = 4'd6,
      DP_DROP_END       = 4'd7,
      DP_STEP_UP        = 4'd8,
      DP_STEP_DOWN      = 4'd9,
      DP_STEP_SEARCH    = 4'd10
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      kind_type         kind;
      logic             empty;
      logic             full;
      logic             bad_pos;
      logic             up_done;
      logic             down_done;
      logic             search_hit;
      logic             search_miss;
      logic [LEN_W-1:0] length;
   } dp_stat_type;

endpackage

// ===== rtl/ole_datapath.sv =====
// Datapath of the ordered list engine: entry memory, count, walk pointer and compare.
module ole_datapath #(
   parameter int CAPACITY   = ole_pkg::DEF_CAPACITY,
   parameter int DATA_WIDTH = ole_pkg::DEF_DATA_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ole_pkg::dp_cmd_type                 cmd,
   input  logic [ole_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [ole_pkg::VALUE_W-1:0]  req_value,
   input  logic [ole_pkg::POS_W-1:0]           req_position,
   output ole_pkg::dp_stat_type                stat
);
   import ole_pkg::*;

   localparam int AW    = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [DATA_WIDTH-1:0] entry_mem_ff [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   kind_type              kind_ff, kind_in;
   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      ptr_ff, ptr_in;
   logic [CNT_W-1:0]      tgt_ff, tgt_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [AW-1:0]         rd_addr_ff, rd_addr_in;

   logic                  rd_en, wr_en;
   logic [AW-1:0]         rd_addr, wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [EXT_W-1:0]      value_ext;
   logic                  up_issue, down_issue, hit, search_issue;

   // The input word is sign-extended and then cut to the stored width.
   assign value_ext    = EXT_W'(req_value);
   assign up_issue     = ptr_ff > tgt_ff;
   assign down_issue   = ptr_ff < count_ff;
   assign hit          = rd_valid_ff && (rd_data_ff == word_ff);
   assign search_issue = (ptr_ff < count_ff) && !hit;

   always_comb begin
      kind_in     = kind_ff;
      word_in     = word_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      tgt_in      = tgt_ff;
      rd_valid_in = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = word_ff;
      case (cmd.op)
         DP_LOAD: begin
            kind_in = kind_type'(req_kind);
            word_in = value_ext[DATA_WIDTH-1:0];
            pos_in  = req_position;
         end
         DP_INIT_UP_HEAD: begin
            ptr_in = count_ff;
            tgt_in = '0;
         end
         DP_INIT_UP_END: begin
            ptr_in = count_ff;
            tgt_in = count_ff;
         end
         DP_INIT_UP_POS: begin
            ptr_in = count_ff;
            tgt_in = CNT_W'(pos_ff);
         end
         DP_INIT_DOWN_HEAD: begin
            ptr_in = CNT_W'(1);
         end
         DP_INIT_SEARCH: begin
            ptr_in = '0;
         end
         DP_DROP_END: begin
            count_in = count_ff - CNT_W'(1);
         end
         DP_STEP_UP: begin
            // Walk from the end toward the target, moving each entry up one slot.
            if (up_issue) begin
               rd_en       = 1'b1;
               rd_addr     = AW'(ptr_ff - CNT_W'(1));
               ptr_in      = ptr_ff - CNT_W'(1);
               rd_valid_in = 1'b1;
            end
            if (rd_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_addr_ff + AW'(1);
               wr_data = rd_data_ff;
            end else if (!up_issue) begin
               wr_en    = 1'b1;
               wr_addr  = AW'(tgt_ff);
               wr_data  = word_ff;
               count_in = count_ff + CNT_W'(1);
            end
         end
         DP_STEP_DOWN: begin
            // Walk toward the end, moving each entry down one slot.
            if (down_issue) begin
               rd_en       = 1'b1;
               rd_addr     = AW'(ptr_ff);
               ptr_in      = ptr_ff + CNT_W'(1);
               rd_valid_in = 1'b1;
            end
            if (rd_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_addr_ff - AW'(1);
               wr_data = rd_data_ff;
            end else if (!down_issue) begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         DP_STEP_SEARCH: begin
            // On a hit the pointer is left on the entry after the match.
            if (hit) begin
               ptr_in = CNT_W'(rd_addr_ff) + CNT_W'(1);
            end else if (search_issue) begin
               rd_en       = 1'b1;
               rd_addr     = AW'(ptr_ff);
               ptr_in      = ptr_ff + CNT_W'(1);
               rd_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
      rd_addr_in = rd_en ? rd_addr : rd_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         rd_valid_ff <= rd_valid_in;
      end
      kind_ff    <= kind_in;
      word_ff    <= word_in;
      pos_ff     <= pos_in;
      ptr_ff     <= ptr_in;
      tgt_ff     <= tgt_in;
      rd_addr_ff <= rd_addr_in;
   end

   assign stat.kind        = kind_ff;
   assign stat.empty       = (count_ff == '0);
   assign stat.full        = (count_ff == CNT_W'(CAPACITY));
   assign stat.bad_pos     = CMP_W'(pos_ff) > CMP_W'(count_ff);
   assign stat.up_done     = !up_issue && !rd_valid_ff;
   assign stat.down_done   = !down_issue && !rd_valid_ff;
   assign stat.search_hit  = hit;
   assign stat.search_miss = !rd_valid_ff && !(ptr_ff < count_ff);
   assign stat.length      = LEN_W'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_no_insert_when_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_STEP_UP && stat.up_done) |-> !stat.full)
      else $error("insert completed into a full list");

   a_no_shift_when_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_STEP_DOWN || cmd.op == DP_DROP_END) |-> !stat.empty)
      else $error("delete walk on an empty list");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (count_ff == $past(count_ff)
                         || count_ff == $past(count_ff) + CNT_W'(1)
                         || count_ff + CNT_W'(1) == $past(count_ff)))
      else $error("entry count moved by more than one");

endmodule

// ===== rtl/ole_ctrl.sv =====
// Controller of the ordered list engine: request sequencing and result register.
module ole_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ole_pkg::STATUS_W-1:0]   rsp_status,
   output logic                           rsp_found,
   output logic [ole_pkg::LEN_W-1:0]      rsp_length,
   output ole_pkg::dp_cmd_type            cmd,
   input  ole_pkg::dp_stat_type           stat
);
   import ole_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE       = 6'b000001,
      S_DECIDE     = 6'b000010,
      S_SHIFT_UP   = 6'b000100,
      S_SHIFT_DOWN = 6'b001000,
      S_SEARCH     = 6'b010000,
      S_DONE       = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   status_type           status_ff, status_in;
   logic                 found_ff, found_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [LEN_W-1:0]     rsp_length_ff, rsp_length_in;
   logic                 load_rsp;

   assign req_ready = (state_ff == S_IDLE);
   assign load_rsp  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      found_in  = found_ff;
      cmd.op    = DP_NOP;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op    = DP_LOAD;
               status_in = ST_OK;
               found_in  = 1'b0;
               state_in  = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_DONE;
            case (stat.kind)
               KIND_INS_HEAD, KIND_INS_END: begin
                  if (stat.full) begin
                     status_in = ST_FULL;
                  end else begin
                     cmd.op   = (stat.kind == KIND_INS_HEAD) ? DP_INIT_UP_HEAD
                                                             : DP_INIT_UP_END;
                     state_in = S_SHIFT_UP;
                  end
               end
               KIND_INS_POS: begin
                  if (stat.bad_pos) begin
                     status_in = ST_BADPOS;
                  end else if (stat.full) begin
                     status_in = ST_FULL;
                  end else begin
                     cmd.op   = DP_INIT_UP_POS;
                     state_in = S_SHIFT_UP;
                  end
               end
               KIND_DEL_HEAD: begin
                  if (stat.empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     cmd.op   = DP_INIT_DOWN_HEAD;
                     state_in = S_SHIFT_DOWN;
                  end
               end
               KIND_DEL_END: begin
                  if (stat.empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     cmd.op = DP_DROP_END;
                  end
               end
               KIND_DEL_VALUE, KIND_SEARCH: begin
                  if (stat.empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     cmd.op   = DP_INIT_SEARCH;
                     state_in = S_SEARCH;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SHIFT_UP: begin
            cmd.op = DP_STEP_UP;
            if (stat.up_done) begin
               state_in = S_DONE;
            end
         end
         S_SHIFT_DOWN: begin
            cmd.op = DP_STEP_DOWN;
            if (stat.down_done) begin
               state_in = S_DONE;
            end
         end
         S_SEARCH: begin
            cmd.op = DP_STEP_SEARCH;
            if (stat.search_hit) begin
               if (stat.kind == KIND_SEARCH) begin
                  found_in = 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_SHIFT_DOWN;
               end
            end else if (stat.search_miss) begin
               status_in = ST_NOTFOUND;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_length_in = rsp_length_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_found_in  = found_ff;
         rsp_length_in = stat.length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_length = rsp_length_ff;

endmodule

// ===== rtl/ordered_list_engine_top.sv =====
// Top level of the ordered list engine: controller plus datapath.
//
// The engine keeps an ordered list of up to CAPACITY signed words in an
// internal memory. Each request beat on the req_ channel carries a kind, a
// value and a position; each one yields exactly one response beat on the
// rsp_ channel with a status, a found flag and the list length afterwards.
// Requests are taken one at a time. Checks that end the request (full,
// empty, bad position, delete at the end) go from the decide state to the
// done state. Insert at position p walks n-p entries of an n-entry list.
// Search and delete by value read one entry per cycle until the match at
// index j, and a delete then moves the remaining n-j-1 entries, one per
// cycle through the memory's single read and write port. The response
// sits in an output register, so a new request beat is taken while the
// previous response waits; a stalled receiver only holds the engine once
// its next result is ready. Reset empties the list at once by clearing the
// entry count; the memory needs no clearing pass.
module ordered_list_engine_top #(
   parameter int CAPACITY   = ole_pkg::DEF_CAPACITY,
   parameter int DATA_WIDTH = ole_pkg::DEF_DATA_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ole_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [ole_pkg::VALUE_W-1:0]  req_value,
   input  logic [ole_pkg::POS_W-1:0]           req_position,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ole_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_found,
   output logic [ole_pkg::LEN_W-1:0]           rsp_length
);
   import ole_pkg::*;

   // Commands flow from the controller to the datapath, status flows back.
   dp_cmd_type  cmd;
   dp_stat_type stat;

   // The controller owns the handshakes and the registered response.
   ole_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_found  (rsp_found),
      .rsp_length (rsp_length),
      .cmd        (cmd),
      .stat       (stat)
   );

   // The datapath latches the request, holds the entries and walks them.
   ole_datapath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_kind     (req_kind),
      .req_value    (req_value),
      .req_position (req_position),
      .stat         (stat)
   );

endmodule

// ===== bench/ole_checker.sv =====
// Checker for the ordered list engine: tracks the list and compares every response beat.
`timescale 1ns / 100ps

module ole_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [ole_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [ole_pkg::VALUE_W-1:0] req_value,
   input  logic [ole_pkg::POS_W-1:0]          req_position,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [ole_pkg::STATUS_W-1:0]       rsp_status,
   input  logic                               rsp_found,
   input  logic [ole_pkg::LEN_W-1:0]          rsp_length,
   output int                                 failures,
   output int                                 pending_count,
   output int                                 model_length,
   output int                                 replies_checked,
   output int                                 peak_length,
   output int                                 full_refusals
);
   import ole_pkg::*;

   localparam int CAPACITY = DEF_CAPACITY;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [LEN_W-1:0]    length;
   } reply_type;

   logic [DEF_DATA_WIDTH-1:0] entries [CAPACITY];
   int                        entry_total = 0;
   reply_type                 expected_replies [$];
   int                        mismatches = 0;
   int                        checked = 0;
   int                        peak = 0;
   int                        refusals = 0;

   function automatic void insert_entry(input int at, input logic [DEF_DATA_WIDTH-1:0] word);
      for (int i = entry_total; i > at; i--) begin
         entries[i] = entries[i-1];
      end
      entries[at] = word;
      entry_total++;
   endfunction

   function automatic void remove_entry(input int at);
      for (int i = at; i + 1 < entry_total; i++) begin
         entries[i] = entries[i+1];
      end
      entry_total--;
   endfunction

   // Index of the first entry equal to word, or -1 when there is none.
   function automatic int locate_entry(input logic [DEF_DATA_WIDTH-1:0] word);
      for (int i = 0; i < entry_total; i++) begin
         if (entries[i] == word) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic reply_type apply_list_request(input logic [KIND_W-1:0] kind,
                                                    input logic [VALUE_W-1:0] value,
                                                    input logic [POS_W-1:0] pos);
      reply_type                 r;
      logic [DEF_DATA_WIDTH-1:0] word;
      int                        hit;
      word = value[DEF_DATA_WIDTH-1:0];
      r.status = ST_OK;
      r.found = 1'b0;
      case (kind)
         KIND_INS_HEAD: begin
            if (entry_total >= CAPACITY) r.status = ST_FULL;
            else insert_entry(0, word);
         end
         KIND_INS_END: begin
            if (entry_total >= CAPACITY) r.status = ST_FULL;
            else insert_entry(entry_total, word);
         end
         KIND_INS_POS: begin
            // A bad position wins over a full list.
            if (int'(pos) > entry_total) r.status = ST_BADPOS;
            else if (entry_total >= CAPACITY) r.status = ST_FULL;
            else insert_entry(int'(pos), word);
         end
         KIND_DEL_HEAD: begin
            if (entry_total == 0) r.status = ST_EMPTY;
            else remove_entry(0);
         end
         KIND_DEL_END: begin
            if (entry_total == 0) r.status = ST_EMPTY;
            else entry_total--;
         end
         KIND_DEL_VALUE: begin
            if (entry_total == 0) begin
               r.status = ST_EMPTY;
            end else begin
               hit = locate_entry(word);
               if (hit < 0) r.status = ST_NOTFOUND;
               else remove_entry(hit);
            end
         end
         KIND_SEARCH: begin
            if (entry_total == 0) begin
               r.status = ST_EMPTY;
            end else begin
               hit = locate_entry(word);
               if (hit < 0) r.status = ST_NOTFOUND;
               else r.found = 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.length = entry_total[LEN_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      reply_type want;
      reply_type got;
      if (reset) begin
         entry_total = 0;
         expected_replies.delete();
      end else begin
         // The response beat belongs to an older request, so it is checked first.
         if (rsp_valid && rsp_ready) begin
            got.status = rsp_status;
            got.found  = rsp_found;
            got.length = rsp_length;
            if (expected_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected response beat: status %0d found %0d length %0d",
                           $time, got.status, got.found, got.length);
            end else begin
               want = expected_replies.pop_front();
               checked++;
               if (got.status !== want.status || got.found !== want.found ||
                   got.length !== want.length) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("%0t: expected %0d/%0d/%0d, got %0d/%0d/%0d (status/found/length)",
                              $time, want.status, want.found, want.length,
                              got.status, got.found, got.length);
               end
            end
         end
         if (req_valid && req_ready) begin
            want = apply_list_request(req_kind, req_value, req_position);
            if (want.status == ST_FULL) refusals++;
            if (entry_total > peak) peak = entry_total;
            expected_replies.push_back(want);
         end
      end
      failures        <= mismatches;
      pending_count   <= expected_replies.size();
      model_length    <= entry_total;
      replies_checked <= checked;
      peak_length     <= peak;
      full_refusals   <= refusals;
   end

endmodule

// ===== bench/tb_ordered_list_engine_top.sv =====
// Testbench top for the ordered list engine: stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps

module tb_ordered_list_engine_top;
   import ole_pkg::*;

   localparam int CAPACITY = DEF_CAPACITY;
   // Kind code 7 has no enum member; the engine must treat it as a no-op.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
   localparam int PHASE_ITEMS  = 420;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 5000;
   localparam int POOL_SIZE    = 12;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [KIND_W-1:0]          req_kind = '0;
   logic signed [VALUE_W-1:0]  req_value = '0;
   logic [POS_W-1:0]           req_position = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic                       rsp_found;
   logic [LEN_W-1:0]           rsp_length;

   int failures;
   int pending_count;
   int model_length;
   int replies_checked;
   int peak_length;
   int full_refusals;

   // Pacing knobs, written by the stimulus process only.
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int hold_asked    = 0;

   int stalled_cycles = 0;
   int requests_sent  = 0;
   bit trend_up       = 1'b1;
   logic [VALUE_W-1:0] value_pool [POOL_SIZE];

   // 4 ns clock, low half first.
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   ordered_list_engine_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_found    (rsp_found),
      .rsp_length   (rsp_length)
   );

   ole_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_length      (rsp_length),
      .failures        (failures),
      .pending_count   (pending_count),
      .model_length    (model_length),
      .replies_checked (replies_checked),
      .peak_length     (peak_length),
      .full_refusals   (full_refusals)
   );

   // Watchdog: counts cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin
      while (stalled_cycles < STALL_LIMIT) @(posedge clock);
      $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
   end

   // Response side. Each cycle the receiver stalls with the current
   // probability, except during a long hold-off, which it counts itself so
   // that the engine fills up and pushes back on the request side.
   initial begin : receiver
      int hold_left;
      int holds_taken;
      hold_left = 0;
      holds_taken = 0;
      forever begin
         @(posedge clock);
         if (hold_asked != holds_taken) begin
            holds_taken = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Offers one request beat and returns at the edge that accepts it. An
   // idle gap, when drawn, drops valid first; otherwise valid stays high and
   // only the payload changes, so back-to-back beats never glitch valid.
   task automatic offer_request(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value,
                                input logic [POS_W-1:0] pos);
      if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_value    <= value;
      req_position <= pos;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   // Stops offering and waits until every predicted response has arrived.
   // The checker's counters are registered and lag each beat, hence the first wait.
   task automatic wait_for_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Values come from a small pool often enough that searches and deletes by
   // value hit, and duplicates show that only the first match is removed.
   function automatic logic [VALUE_W-1:0] pick_value();
      if ($urandom_range(99) < 55) return value_pool[$urandom_range(POOL_SIZE-1)];
      return $urandom();
   endfunction

   // Mostly legal positions for the current length, some past the end and
   // some raw 7-bit noise.
   function automatic logic [POS_W-1:0] pick_position();
      int r;
      r = $urandom_range(99);
      if (r < 85) return POS_W'($urandom_range(model_length, 0));
      if (r < 95) return POS_W'($urandom_range(127, model_length + 1));
      return POS_W'($urandom());
   endfunction

   // One random request. The mix drifts between a growing and a shrinking
   // trend so the list spends time near empty, in the middle and at full.
   task automatic send_random_request();
      int                r;
      logic [KIND_W-1:0] kind;
      if (model_length >= CAPACITY - 1 && $urandom_range(2) == 0) trend_up = 1'b0;
      else if (model_length <= 1) trend_up = 1'b1;
      else if ($urandom_range(99) == 0) trend_up = !trend_up;
      r = $urandom_range(99);
      if (trend_up) begin
         if (r < 18) kind = KIND_INS_HEAD;
         else if (r < 36) kind = KIND_INS_END;
         else if (r < 60) kind = KIND_INS_POS;
         else if (r < 68) kind = KIND_DEL_HEAD;
         else if (r < 76) kind = KIND_DEL_END;
         else if (r < 86) kind = KIND_DEL_VALUE;
         else if (r < 98) kind = KIND_SEARCH;
         else kind = KIND_UNUSED;
      end else begin
         if (r < 8) kind = KIND_INS_HEAD;
         else if (r < 16) kind = KIND_INS_END;
         else if (r < 25) kind = KIND_INS_POS;
         else if (r < 43) kind = KIND_DEL_HEAD;
         else if (r < 61) kind = KIND_DEL_END;
         else if (r < 81) kind = KIND_DEL_VALUE;
         else if (r < 98) kind = KIND_SEARCH;
         else kind = KIND_UNUSED;
      end
      offer_request(kind, pick_value(), pick_position());
      // Now and then the sender drains the engine completely before going on.
      if ($urandom_range(149) == 0) wait_for_replies();
   endtask

   initial begin : stimulus
      int idle_table [4];
      int stall_table [4];
      int kind_pick;
      // Handshake phases: no idling, sender idle, receiver stalling, both.
      idle_table  = '{0, 76, 0, 24};
      stall_table = '{0, 0, 76, 24};

      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, no idling. Every delete and search kind on an empty list first.
      offer_request(KIND_DEL_HEAD, 32'h0, 7'd0);
      offer_request(KIND_DEL_END, 32'h0, 7'd0);
      offer_request(KIND_DEL_VALUE, 32'h5, 7'd0);
      offer_request(KIND_SEARCH, 32'h5, 7'd0);
      // Appending to an empty list makes the value the only entry.
      offer_request(KIND_INS_END, 32'h7FFF_FFFF, 7'd0);
      // Inserting at position zero keeps the old list behind the new entry.
      offer_request(KIND_INS_POS, 32'h8000_0000, 7'd0);
      // Positions past the length are refused; the second is just one past.
      offer_request(KIND_INS_POS, 32'h1, 7'd127);
      offer_request(KIND_INS_POS, 32'h2, 7'd3);
      offer_request(KIND_INS_POS, 32'hFFFF_FFFF, 7'd2);
      offer_request(KIND_INS_HEAD, 32'h0, 7'h55);
      offer_request(KIND_SEARCH, 32'h8000_0000, 7'd0);
      offer_request(KIND_SEARCH, 32'h1234_5678, 7'd0);
      offer_request(KIND_DEL_VALUE, 32'h1234_5678, 7'd0);
      // A duplicate value: only its first occurrence goes away.
      offer_request(KIND_INS_END, 32'h8000_0000, 7'd0);
      offer_request(KIND_DEL_VALUE, 32'h8000_0000, 7'd0);
      offer_request(KIND_SEARCH, 32'h8000_0000, 7'd0);
      offer_request(KIND_UNUSED, 32'hA5A5_A5A5, 7'h2A);
      offer_request(KIND_DEL_HEAD, 32'h0, 7'd0);
      offer_request(KIND_DEL_END, 32'h0, 7'd0);
      offer_request(KIND_INS_POS, 32'h5A5A_5A5A, 7'd1);
      wait_for_replies();

      // Fill the list to capacity with random inserts, then knock on the
      // full list with every insert kind, including a bad position, which
      // is reported ahead of fullness.
      while (model_length < CAPACITY) begin
         kind_pick = $urandom_range(2);
         if (kind_pick == 0) offer_request(KIND_INS_HEAD, pick_value(), pick_position());
         else if (kind_pick == 1) offer_request(KIND_INS_END, pick_value(), pick_position());
         else offer_request(KIND_INS_POS, pick_value(), POS_W'($urandom_range(model_length, 0)));
      end
      offer_request(KIND_INS_HEAD, pick_value(), 7'd0);
      offer_request(KIND_INS_END, pick_value(), 7'd0);
      offer_request(KIND_INS_POS, pick_value(), 7'd64);
      offer_request(KIND_INS_POS, pick_value(), 7'd65);
      offer_request(KIND_SEARCH, value_pool[$urandom_range(POOL_SIZE-1)], 7'd0);
      offer_request(KIND_DEL_END, 32'h0, 7'd0);
      wait_for_replies();

      // Long receiver hold-off while the sender keeps offering beats, so the
      // output register fills and the engine stops taking requests.
      hold_asked++;
      repeat (16) send_random_request();
      wait_for_replies();

      for (int phase = 0; phase < 4; phase++) begin
         req_idle_pct  = idle_table[phase];
         rsp_stall_pct = stall_table[phase];
         repeat (PHASE_ITEMS) send_random_request();
         wait_for_replies();
      end

      // Quiet tail: a walk over a full list is the slowest request, so give
      // that much time for any stray response beat to show up.
      repeat (CAPACITY + 20) @(posedge clock);

      $display("Run covered %0d request beats and %0d checked response beats in four phases.",
               requests_sent, replies_checked);
      $display("The list peaked at %0d entries; %0d inserts were refused as full; %0d mismatches.",
               peak_length, full_refusals, failures);
      if (failures == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
